FILE: design/pfcrc_pkg.sv
// Package for the parity-framed CRC-16 block.
// Holds the field widths and CRC constants shared by the datapath and the top level.
// No dependencies.
package pfcrc_pkg;

    // Field widths.
    localparam int CHAR_W = 7;
    localparam int BYTE_W = CHAR_W + 1;
    localparam int CRC_W  = 16;

    // CRC-16/UMTS generator and initial remainder.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

endpackage : pfcrc_pkg

FILE: design/parity_framed_crc16.sv
// Top level of the parity-framed CRC-16 block: input register, remainder register
// and result register around pfcrc_core. Depends on pfcrc_pkg and pfcrc_core.
//
// Each transaction on the s_ channel carries one 7-bit character; the block frames it
// as (character << 1) with an even-parity bit in bit 0 and feeds the eight framed bits,
// most significant first, into a running CRC-16 (polynomial 0x8005, initial value zero,
// no reflection, no final XOR). Every input transaction gives exactly one m_ transaction
// holding the framed byte and the remainder after it. Setting s_start_message clears the
// remainder before that character. The block takes one character per clock cycle while
// m_ready stays high; each character passes through the input register and then the
// result register, and that rate is set by the loop through the remainder register.
module parity_framed_crc16 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pfcrc_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                          s_start_message,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfcrc_pkg::BYTE_W-1:0]  m_framed_byte,
    output logic [pfcrc_pkg::CRC_W-1:0]   m_crc_value
);
    import pfcrc_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              start_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] framed_reg;
    logic [CRC_W-1:0]  crc_out_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_seed;
    logic [CRC_W-1:0]  crc_next;
    logic [BYTE_W-1:0] framed_next;
    logic              out_advance;
    logic              in_advance;

    // Stage handshakes: the result register frees up when empty or being taken.
    assign out_advance = !out_valid_reg || m_ready;
    assign in_advance  = in_valid_reg && out_advance;
    assign s_ready     = !in_valid_reg || out_advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg  <= s_char_code;
            start_reg <= s_start_message;
        end
    end

    // A start flag restarts the remainder from its initial value.
    assign crc_seed = start_reg ? CRC_INIT : crc_reg;

    pfcrc_core u_core (
        .char_code   (char_reg),
        .crc_in      (crc_seed),
        .framed_byte (framed_next),
        .crc_out     (crc_next)
    );

    // Running remainder, updated as each character moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (in_advance) begin
            crc_reg <= crc_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            framed_reg  <= framed_next;
            crc_out_reg <= crc_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_framed_byte = framed_reg;
    assign m_crc_value   = crc_out_reg;

endmodule : parity_framed_crc16

FILE: design/pfcrc_core.sv
// Combinational datapath: even-parity framing of one character and the CRC update.
// Depends on pfcrc_pkg for widths and the generator polynomial.
module pfcrc_core (
    input  logic [pfcrc_pkg::CHAR_W-1:0] char_code,
    input  logic [pfcrc_pkg::CRC_W-1:0]  crc_in,
    output logic [pfcrc_pkg::BYTE_W-1:0] framed_byte,
    output logic [pfcrc_pkg::CRC_W-1:0]  crc_out
);
    import pfcrc_pkg::*;

    // The parity bit makes the count of ones in the framed byte even.
    assign framed_byte = {char_code, ^char_code};

    // Eight XOR-shift steps, most significant bit of the framed byte first.
    always_comb begin
        logic [CRC_W-1:0] rem;
        rem = crc_in;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (rem[CRC_W-1] ^ framed_byte[k]) begin
                rem = {rem[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                rem = {rem[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = rem;
    end

endmodule : pfcrc_core

FILE: design/pfcrc_checker.sv
// Port-level checks for parity_framed_crc16, attached to it by the bind below.
// Depends on pfcrc_pkg for the field widths.
module pfcrc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [pfcrc_pkg::CHAR_W-1:0]  s_char_code,
    input logic                          s_start_message,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pfcrc_pkg::BYTE_W-1:0]  m_framed_byte,
    input logic [pfcrc_pkg::CRC_W-1:0]   m_crc_value
);
    import pfcrc_pkg::*;

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // Every framed byte carries an even number of ones.
    a_even_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(^m_framed_byte))
        else $error("framed byte has odd parity");

    // A free result side never holds back the input side.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although results are being taken");

    // A transaction taken in is offered as a result, once it has moved through the input
    // register, if the result side was free while it sat there.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted character did not produce a result in time");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_framed_byte) && $stable(m_crc_value))
        else $error("stalled result changed or vanished");

endmodule : pfcrc_checker

bind parity_framed_crc16 pfcrc_checker u_checker (.*);

FILE: verif/parity_framed_crc16_tb.sv
// Self-checking testbench for parity_framed_crc16: parity framing and running CRC-16.
// Depends on pfcrc_pkg and the parity_framed_crc16 top level only.
// A local model predicts each result, and a monitor compares results in arrival order.
`timescale 1ns / 1ps

module parity_framed_crc16_tb;

    import pfcrc_pkg::*;

    // Expected content of one result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] framed;
        logic [CRC_W-1:0]  crc;
    } crc_result_t;

    // Patterns that the result side uses to hold off m_ready.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_ONE_IN_THREE,
        READY_MOSTLY_STALLED
    } stall_mode_t;

    localparam int NUM_RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES     = 8;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_char_code     = '0;
    logic              s_start_message = 1'b0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [BYTE_W-1:0] m_framed_byte;
    logic [CRC_W-1:0]  m_crc_value;

    crc_result_t       pending_results[$];
    logic [CRC_W-1:0]  running_crc     = CRC_INIT;
    int                burst_left      = 0;
    int                sent_count      = 0;
    int                checked_count   = 0;
    int                mismatch_count  = 0;

    stall_mode_t       stall_mode      = READY_ALWAYS;
    int                stall_left      = 0;
    int unsigned       stall_phase     = 0;

    parity_framed_crc16 uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_start_message (s_start_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_framed_byte   (m_framed_byte),
        .m_crc_value     (m_crc_value)
    );

    // Clock with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The character moves up one place and even parity fills bit zero.
    function automatic logic [BYTE_W-1:0] frame_with_parity(input logic [CHAR_W-1:0] code);
        return {code, ^code};
    endfunction

    // Feeds one framed byte, most significant bit first, into the remainder.
    function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] rem,
                                                        input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = rem;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (r[CRC_W-1] ^ data[i]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string field, input logic [CRC_W-1:0] got,
                                   input logic [CRC_W-1:0] want);
        mismatch_count++;
        $display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, checked_count, field, got, want);
    endtask

    // Sends one character transaction; bursts of random length are separated by random
    // gaps. The expected result is queued as the transaction is presented, since the
    // block keeps order and every presented transaction is eventually accepted.
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic start);
        crc_result_t want;
        int          gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        if (start) begin
            running_crc = CRC_INIT;
        end
        want.framed = frame_with_parity(code);
        running_crc = crc_after_byte(running_crc, want.framed);
        want.crc    = running_crc;
        pending_results.push_back(want);
        s_valid         <= 1'b1;
        s_char_code     <= code;
        s_start_message <= start;
        sent_count++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sends one message: the start flag on the first character only.
    task automatic send_message(input int len, input bit printable);
        logic [CHAR_W-1:0] code;
        for (int i = 0; i < len; i++) begin
            code = printable ? CHAR_W'($urandom_range(32, 126)) : CHAR_W'($urandom);
            send_char(code, i == 0);
        end
    endtask

    // Without any start flag the remainder begins from its reset value of zero.
    task automatic test_first_char_after_reset();
        send_char(CHAR_W'(8'h41), 1'b0);
        send_char(CHAR_W'(8'h42), 1'b0);
        send_char(CHAR_W'(8'h43), 1'b0);
    endtask

    // Extreme and alternating character codes, with and without the start flag.
    task automatic test_character_extremes();
        send_char('0, 1'b1);
        send_char('1, 1'b0);
        send_char('0, 1'b0);
        send_char('1, 1'b1);
        send_char(CHAR_W'(8'h01), 1'b0);
        send_char(CHAR_W'(8'h40), 1'b0);
        send_char(CHAR_W'(8'h55), 1'b1);
        send_char(CHAR_W'(8'h2A), 1'b0);
        send_char(CHAR_W'(8'h7E), 1'b0);
        send_char(CHAR_W'(8'h3F), 1'b0);
    endtask

    // A start flag part way through clears the remainder, even on back-to-back starts.
    task automatic test_message_restart();
        send_char(CHAR_W'(8'h31), 1'b1);
        send_char(CHAR_W'(8'h32), 1'b0);
        send_char(CHAR_W'(8'h33), 1'b1);
        send_char(CHAR_W'(8'h33), 1'b1);
        send_char(CHAR_W'(8'h34), 1'b0);
        send_char('0, 1'b1);
        send_char('0, 1'b0);
    endtask

    // Mostly well-formed messages of random length, with stray single characters
    // carrying a random start flag as noise.
    task automatic test_random_messages();
        int kind;
        while (sent_count < NUM_RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_char(CHAR_W'($urandom), 1'($urandom));
            end else begin
                send_message($urandom_range(1, 24), kind < 4);
            end
        end
    endtask

    // The remainder keeps running over a message far longer than usual.
    task automatic test_long_message();
        send_message(300, 1'b0);
    endtask

    // Result side: m_ready follows a pattern that changes every so often.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_left == 0) begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                stall_left <= $urandom_range(20, 200);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                READY_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                READY_RANDOM: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                READY_ONE_IN_THREE: begin
                    m_ready <= (stall_phase % 3 == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // Each accepted result transaction is compared with the oldest expectation.
    always @(posedge aclk) begin
        crc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("[%0t] MISMATCH unexpected result: framed 0x%0h crc 0x%0h",
                         $time, m_framed_byte, m_crc_value);
            end else begin
                want = pending_results.pop_front();
                if (m_framed_byte !== want.framed) begin
                    report_mismatch("framed_byte", CRC_W'(m_framed_byte), CRC_W'(want.framed));
                end
                if (m_crc_value !== want.crc) begin
                    report_mismatch("crc_value", m_crc_value, want.crc);
                end
            end
            checked_count++;
        end
    end

    // Main sequence: reset, the directed tests, the random tests, then drain.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_char_after_reset();
        test_character_extremes();
        test_message_restart();
        test_long_message();
        test_random_messages();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule : parity_framed_crc16_tb

FILE: parity_framed_crc16.f
design/pfcrc_pkg.sv
design/pfcrc_core.sv
design/parity_framed_crc16.sv
design/pfcrc_checker.sv
verif/parity_framed_crc16_tb.sv
